>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Clocked property, checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/ukf_pkg.sv
// Shared constants, types and register codes for the record keyword filter.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ukf_pkg;

    localparam int KEY_MAX      = 8;
    localparam int LENGTH_BITS  = 16;

    localparam int BYTE_W       = 8;
    localparam int OWNER_W      = 32;
    localparam int KEY_BYTES_W  = 64;
    localparam int KEY_LEN_W    = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;

    localparam int WIN_BYTES    = (KEY_MAX > 1) ? KEY_MAX - 1 : 1;
    localparam int WIN_W        = WIN_BYTES * BYTE_W;
    localparam int FILL_W       = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LEN_SEL_W    = $clog2(KEY_MAX + 1);

    localparam int IN_TDATA_W   = BYTE_W;
    localparam int OUT_TDATA_W  = ((LENGTH_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 1;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OWNER_ID       = 2'd0,
        REG_KEYWORD_BYTES  = 2'd1,
        REG_KEYWORD_LENGTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [OWNER_W-1:0]     owner_id;
        logic [KEY_BYTES_W-1:0] keyword_bytes;
        logic [KEY_LEN_W-1:0]   key_count;
    } cfg_t;

    typedef struct packed {
        logic                   valid;
        logic [LENGTH_BITS-1:0] rec_length;
        logic                   keyword_found;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/user_record_keyword_filter.sv
// Top level of the record keyword filter: input register, parser, result register.
// Depends on ukf_pkg, ukf_cfg_regs and ukf_parser.
//
//  channel  direction  transfer on              payload
//  s_       in         s_tvalid && s_tready     tdata: data_byte; tlast: end_of_data
//  m_       out        m_tvalid && m_tready     tdata: rec_length; tuser: keyword_found
//  cfg_     in         cfg_wr_en                cfg_wr_index, cfg_wr_data
//
// One byte per cycle while the output is not stalled; a newline byte passes the input register,
// the parser update and the result register before its result leaves.
// Reset is synchronous, active low, and clears parser state and the valid flags.
// A stalled result holds; the input register still takes one more byte behind it.
`default_nettype none

module user_record_keyword_filter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ukf_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [ukf_pkg::OUT_TDATA_W-1:0]       m_tdata,  // [15:0] rec_length
    output logic [ukf_pkg::OUT_TUSER_W-1:0]       m_tuser,  // [0] keyword_found
    input  wire logic                             cfg_wr_en,
    input  wire logic [ukf_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input  wire logic [ukf_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import ukf_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic                   out_valid_reg;
    logic [LENGTH_BITS-1:0] out_length_reg;
    logic                   out_found_reg;

    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    ukf_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    ukf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .end_of_data (in_last_reg),
        .cfg         (cfg),
        .result      (result)
    );

    // hold the byte until the parser can take it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_length_reg <= result.rec_length;
            out_found_reg  <= result.keyword_found;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_length_reg);
    assign m_tuser  = OUT_TUSER_W'(out_found_reg);

endmodule

`default_nettype wire

>>> rtl/ukf_cfg_regs.sv
// Configuration register bank: owner id, keyword bytes and keyword length.
// Depends on ukf_pkg.
`default_nettype none

module ukf_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ukf_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [ukf_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output ukf_pkg::cfg_t                        cfg
);
    import ukf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_wr_index))
                REG_OWNER_ID: begin
                    cfg_next.owner_id = cfg_wr_data[OWNER_W-1:0];
                end
                REG_KEYWORD_BYTES: begin
                    cfg_next.keyword_bytes = cfg_wr_data[KEY_BYTES_W-1:0];
                end
                REG_KEYWORD_LENGTH: begin
                    cfg_next.key_count = cfg_wr_data[KEY_LEN_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/ukf_matcher.sv
// Parallel window compare: does the keyword end at the current body byte.
// Depends on ukf_pkg.
`default_nettype none

module ukf_matcher (
    input  wire logic [ukf_pkg::BYTE_W-1:0]      cur_byte,
    input  wire logic [ukf_pkg::WIN_W-1:0]       recent,
    input  wire logic [ukf_pkg::FILL_W-1:0]      fill,
    input  wire logic [ukf_pkg::KEY_BYTES_W-1:0] keyword_bytes,
    input  wire logic [ukf_pkg::LEN_SEL_W-1:0]   key_len,
    output logic                                 match
);
    import ukf_pkg::*;

    logic [BYTE_W-1:0] hist [KEY_MAX];
    logic              len_match [KEY_MAX+1];

    always_comb begin
        hist[0] = cur_byte;
        for (int k = 1; k < KEY_MAX; k++) begin
            hist[k] = recent[(k-1)*BYTE_W +: BYTE_W];
        end
    end

    always_comb begin
        len_match[0] = 1'b0;
        for (int l = 1; l <= KEY_MAX; l++) begin
            len_match[l] = (int'(fill) >= l - 1);
            for (int i = 0; i < KEY_MAX; i++) begin
                if (i < l) begin
                    len_match[l] = len_match[l] &&
                        (hist[l-1-i] == keyword_bytes[i*BYTE_W +: BYTE_W]);
                end
            end
        end
    end

    assign match = len_match[key_len];

endmodule

`default_nettype wire

>>> rtl/ukf_parser.sv
// Record parser: id assembly, body length, sliding window and result build.
// Depends on ukf_pkg and ukf_matcher.
`default_nettype none

module ukf_parser (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire logic [ukf_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                      end_of_data,
    input  ukf_pkg::cfg_t                  cfg,
    output ukf_pkg::result_t               result
);
    import ukf_pkg::*;

    typedef enum logic [2:0] {
        PH_ID0,
        PH_ID1,
        PH_ID2,
        PH_ID3,
        PH_SEP,
        PH_BODY
    } phase_t;

    phase_t                 phase_reg,  phase_next;
    logic [OWNER_W-1:0]     owner_reg,  owner_next;
    logic [LENGTH_BITS-1:0] count_reg,  count_next;
    logic [WIN_W-1:0]       recent_reg, recent_next;
    logic [FILL_W-1:0]      fill_reg,   fill_next;
    logic                   found_reg,  found_next;
    logic                   zero_reg,   zero_next;

    logic [LEN_SEL_W-1:0]   key_len;
    logic                   match;

    always_comb begin
        if (cfg.key_count > KEY_LEN_W'(KEY_MAX)) begin
            key_len = LEN_SEL_W'(KEY_MAX);
        end else begin
            key_len = LEN_SEL_W'(cfg.key_count);
        end
    end

    ukf_matcher u_matcher (
        .cur_byte      (data_byte),
        .recent        (recent_reg),
        .fill          (fill_reg),
        .keyword_bytes (cfg.keyword_bytes),
        .key_len       (key_len),
        .match         (match)
    );

    always_comb begin
        phase_next  = phase_reg;
        owner_next  = owner_reg;
        count_next  = count_reg;
        recent_next = recent_reg;
        fill_next   = fill_reg;
        found_next  = found_reg;
        zero_next   = zero_reg;
        result      = '0;

        if (step) begin
            unique case (phase_reg)
                PH_ID0: begin
                    owner_next[7:0] = data_byte;
                    phase_next      = PH_ID1;
                end
                PH_ID1: begin
                    owner_next[15:8] = data_byte;
                    phase_next       = PH_ID2;
                end
                PH_ID2: begin
                    owner_next[23:16] = data_byte;
                    phase_next        = PH_ID3;
                end
                PH_ID3: begin
                    owner_next[31:24] = data_byte;
                    phase_next        = PH_SEP;
                end
                PH_SEP: begin
                    phase_next  = PH_BODY;
                    count_next  = '0;
                    recent_next = '0;
                    fill_next   = '0;
                    found_next  = 1'b0;
                    zero_next   = 1'b0;
                end
                PH_BODY: begin
                    if (count_reg != '1) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (!zero_reg) begin
                        if (data_byte == ZERO_BYTE) begin
                            zero_next = 1'b1;
                        end else begin
                            if (match) begin
                                found_next = 1'b1;
                            end
                            recent_next = WIN_W'({recent_reg, data_byte});
                            if (fill_reg < FILL_W'(KEY_MAX - 1)) begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                    end
                    if (data_byte == NEWLINE_BYTE) begin
                        result.valid         = (owner_reg == cfg.owner_id);
                        result.rec_length    = count_next;
                        result.keyword_found = found_next || (key_len == '0);
                        phase_next  = PH_ID0;
                        owner_next  = '0;
                        count_next  = '0;
                        recent_next = '0;
                        fill_next   = '0;
                        found_next  = 1'b0;
                        zero_next   = 1'b0;
                    end
                end
                default: begin
                    phase_next = PH_ID0;
                end
            endcase

            if (end_of_data) begin
                phase_next  = PH_ID0;
                owner_next  = '0;
                count_next  = '0;
                recent_next = '0;
                fill_next   = '0;
                found_next  = 1'b0;
                zero_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ID0;
            owner_reg  <= '0;
            count_reg  <= '0;
            recent_reg <= '0;
            fill_reg   <= '0;
            found_reg  <= 1'b0;
            zero_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            owner_reg  <= owner_next;
            count_reg  <= count_next;
            recent_reg <= recent_next;
            fill_reg   <= fill_next;
            found_reg  <= found_next;
            zero_reg   <= zero_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ukf_checker.sv
// Port-level checks for the record keyword filter, bound to the top level.
// Depends on ukf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ukf_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [ukf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input wire logic [ukf_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import ukf_pkg::*;

    logic out_stall;

    assign out_stall = m_tvalid && !m_tready;

    `ASSERT_RST(a_out_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable({m_tdata, m_tuser}))
    `ASSERT_RST(a_len_nonzero, aclk, aresetn, m_tvalid |-> m_tdata[LENGTH_BITS-1:0] != '0)
    `ASSERT_RST(a_ready_when_free, aclk, aresetn, !m_tvalid || m_tready |-> s_tready)
    `ASSERT_ALWAYS(a_quiet_after_reset, aclk, !aresetn |=> !m_tvalid)

endmodule

bind user_record_keyword_filter ukf_checker u_ukf_checker (.*);

`default_nettype wire
